### hdl/zics_pkg.sv
// Shared types and constants for the Zipf inverse-CDF sampler.
`timescale 1ns / 1ps

package zics_pkg;

	localparam int IDX_W    = 10;
	localparam int WEIGHT_W = 32;
	localparam int RAND_W   = 31;
	localparam int RANK_W   = 10;
	localparam int SIZE_W   = 11;
	localparam int CFG_W    = 32;
	// r * total_weight and cdf * (2^31 - 1) both fit in 63 bits
	localparam int PROD_W   = RAND_W + WEIGHT_W;

	localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_DRAW = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_TABLE_SIZE   = 1'b0,
		REG_TOTAL_WEIGHT = 1'b1
	} cfg_reg_t;

	// per-stage control that travels with each beat
	typedef struct packed {
		logic draw;  // draw beat, produces one result
		logic wr;    // load beat with an in-range index
		logic pend;  // compare against this stage's read data is outstanding
	} ctl_t;

endpackage

### hdl/zics_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module zics_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/zics_prep.sv
// Input register, sample scaling, load bound and search bounds setup.
`timescale 1ns / 1ps

module zics_prep #(
	parameter int TABLE_DEPTH = 1024,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          cmd,
	input  logic [zics_pkg::IDX_W-1:0]    entry_index,
	input  logic [zics_pkg::WEIGHT_W-1:0] entry_weight,
	input  logic [zics_pkg::RAND_W-1:0]   random_value,
	input  logic [zics_pkg::SIZE_W-1:0]   table_size,
	input  logic [zics_pkg::WEIGHT_W-1:0] total_weight,
	output zics_pkg::ctl_t                ctl_o,
	output logic [AW-1:0]                 lo_o,
	output logic [AW-1:0]                 hi_o,
	output logic [AW-1:0]                 mid_o,
	output logic [AW-1:0]                 addr_o,
	output logic [zics_pkg::PROD_W-1:0]   scaled_o,
	output logic [zics_pkg::PROD_W-1:0]   bound_o
);

	localparam logic [AW-1:0] HI_MAX = AW'(TABLE_DEPTH - 1);

	logic                          draw_s1;
	logic                          wr_s1;
	logic [zics_pkg::IDX_W-1:0]    idx_s1;
	logic [zics_pkg::WEIGHT_W-1:0] weight_s1;
	logic [zics_pkg::RAND_W-1:0]   rnd_s1;

	zics_pkg::ctl_t                ctl_s2;
	logic [AW-1:0]                 hi_s2;
	logic [AW-1:0]                 addr_s2;
	logic [zics_pkg::PROD_W-1:0]   scaled_s2;
	logic [zics_pkg::PROD_W-1:0]   bound_s2;
	logic [AW-1:0]                 hi_init;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_s1 <= 1'b0;
			wr_s1   <= 1'b0;
		end else begin
			draw_s1 <= accept && (cmd == zics_pkg::CMD_DRAW);
			wr_s1   <= accept && (cmd == zics_pkg::CMD_LOAD)
				&& (32'(entry_index) < 32'(TABLE_DEPTH));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1    <= entry_index;
			weight_s1 <= entry_weight;
			rnd_s1    <= random_value;
		end
	end

	// size saturates at the depth; sizes of zero or one give an empty search
	always_comb begin
		if (32'(table_size) >= 32'(TABLE_DEPTH)) begin
			hi_init = HI_MAX;
		end else if (table_size < 11'd2) begin
			hi_init = '0;
		end else begin
			hi_init = AW'(table_size - 11'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.draw <= draw_s1;
			ctl_s2.wr   <= wr_s1;
			ctl_s2.pend <= 1'b0;
		end
	end

	// bound = cdf * (2^31 - 1), stored so each level only compares
	always_ff @(posedge clk) begin
		hi_s2     <= hi_init;
		addr_s2   <= AW'(idx_s1);
		scaled_s2 <= zics_pkg::PROD_W'(rnd_s1) * zics_pkg::PROD_W'(total_weight);
		bound_s2  <= (zics_pkg::PROD_W'(weight_s1) << zics_pkg::RAND_W)
			- zics_pkg::PROD_W'(weight_s1);
	end

	assign ctl_o    = ctl_s2;
	assign lo_o     = '0;
	assign hi_o     = hi_s2;
	assign mid_o    = '0;
	assign addr_o   = addr_s2;
	assign scaled_o = scaled_s2;
	assign bound_o  = bound_s2;

endmodule

### hdl/zics_level.sv
// One binary search level: resolves the previous compare, reads its own table copy.
`timescale 1ns / 1ps

module zics_level #(
	parameter int TABLE_DEPTH = 1024,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  zics_pkg::ctl_t              ctl_i,
	input  logic [AW-1:0]               lo_i,
	input  logic [AW-1:0]               hi_i,
	input  logic [AW-1:0]               mid_i,
	input  logic [AW-1:0]               addr_i,
	input  logic [zics_pkg::PROD_W-1:0] scaled_i,
	input  logic [zics_pkg::PROD_W-1:0] bound_i,
	input  logic [zics_pkg::PROD_W-1:0] rd_i,
	output zics_pkg::ctl_t              ctl_o,
	output logic [AW-1:0]               lo_o,
	output logic [AW-1:0]               hi_o,
	output logic [AW-1:0]               mid_o,
	output logic [AW-1:0]               addr_o,
	output logic [zics_pkg::PROD_W-1:0] scaled_o,
	output logic [zics_pkg::PROD_W-1:0] bound_o,
	output logic [zics_pkg::PROD_W-1:0] rd_o
);

	logic          below;
	logic [AW-1:0] lo_r;
	logic [AW-1:0] hi_r;
	logic [AW:0]   sum;
	logic          active;
	logic [AW-1:0] mid;

	zics_pkg::ctl_t              ctl_s1;
	logic [AW-1:0]               lo_s1;
	logic [AW-1:0]               hi_s1;
	logic [AW-1:0]               mid_s1;
	logic [AW-1:0]               addr_s1;
	logic [zics_pkg::PROD_W-1:0] scaled_s1;
	logic [zics_pkg::PROD_W-1:0] bound_s1;

	always_comb begin
		below  = scaled_i < rd_i;
		lo_r   = (ctl_i.pend && !below) ? mid_i : lo_i;
		hi_r   = (ctl_i.pend && below) ? mid_i : hi_i;
		sum    = (AW+1)'(lo_r) + (AW+1)'(hi_r);
		mid    = sum[AW:1];
		active = ((AW+1)'(lo_r) + (AW+1)'(1)) < (AW+1)'(hi_r);
	end

	// loads walk down the pipe, so every copy sees them in item order
	zics_ram #(
		.WIDTH(zics_pkg::PROD_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl_i.wr),
		.waddr(addr_i),
		.wdata(bound_i),
		.raddr(mid),
		.rdata(rd_o)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.draw <= ctl_i.draw;
			ctl_s1.wr   <= ctl_i.wr;
			ctl_s1.pend <= ctl_i.draw && active;
		end
	end

	always_ff @(posedge clk) begin
		lo_s1     <= lo_r;
		hi_s1     <= hi_r;
		mid_s1    <= mid;
		addr_s1   <= addr_i;
		scaled_s1 <= scaled_i;
		bound_s1  <= bound_i;
	end

	assign ctl_o    = ctl_s1;
	assign lo_o     = lo_s1;
	assign hi_o     = hi_s1;
	assign mid_o    = mid_s1;
	assign addr_o   = addr_s1;
	assign scaled_o = scaled_s1;
	assign bound_o  = bound_s1;

endmodule

### hdl/zipf_inverse_cdf_sampler.sv
// Top level of the Zipf inverse-CDF rank sampler.
// Takes one command per clock once busy drops (after reset release; busy then
// stays low). A load writes one cumulative Q16.16 weight; a draw returns its
// rank on rank with done high for one cycle after it passes the input register,
// the prep register, NLEV search levels and the output register, where
// NLEV = clog2(TABLE_DEPTH-1) (minimum 1). The search runs one level per
// pipeline stage, each level with its own copy of the table in a RAM; loads
// pass down the same pipe and update each copy in order, so draws and loads
// may be freely interleaved. There is no backpressure: results must be taken
// as they appear. Write the config registers only with no draw in flight.
`timescale 1ns / 1ps

module zipf_inverse_cdf_sampler #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [zics_pkg::IDX_W-1:0]    entry_index,
	input  logic [zics_pkg::WEIGHT_W-1:0] entry_weight,
	input  logic [zics_pkg::RAND_W-1:0]   random_value,
	output logic                          done,
	output logic [zics_pkg::RANK_W-1:0]   rank,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [zics_pkg::CFG_W-1:0]    cfg_data
);

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int NLEV = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH - 1) : 1;

	logic                          run_q;
	logic [zics_pkg::SIZE_W-1:0]   table_size_q;
	logic [zics_pkg::WEIGHT_W-1:0] total_weight_q;
	logic                          done_q;
	logic [zics_pkg::RANK_W-1:0]   rank_q;

	zics_pkg::ctl_t              ctl    [NLEV+1];
	logic [AW-1:0]               lo     [NLEV+1];
	logic [AW-1:0]               hi     [NLEV+1];
	logic [AW-1:0]               mid    [NLEV+1];
	logic [AW-1:0]               addr   [NLEV+1];
	logic [zics_pkg::PROD_W-1:0] scaled [NLEV+1];
	logic [zics_pkg::PROD_W-1:0] bound  [NLEV+1];
	logic [zics_pkg::PROD_W-1:0] rd     [NLEV+1];

	logic          accept;
	logic [AW-1:0] lo_final;

	assign accept    = start && !busy;
	assign busy      = !run_q;
	assign cfg_ready = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q   <= zics_pkg::TABLE_SIZE_RST;
			total_weight_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				zics_pkg::REG_TABLE_SIZE: begin
					table_size_q <= cfg_data[zics_pkg::SIZE_W-1:0];
				end
				zics_pkg::REG_TOTAL_WEIGHT: begin
					total_weight_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	zics_prep #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (cmd),
		.entry_index (entry_index),
		.entry_weight(entry_weight),
		.random_value(random_value),
		.table_size  (table_size_q),
		.total_weight(total_weight_q),
		.ctl_o       (ctl[0]),
		.lo_o        (lo[0]),
		.hi_o        (hi[0]),
		.mid_o       (mid[0]),
		.addr_o      (addr[0]),
		.scaled_o    (scaled[0]),
		.bound_o     (bound[0])
	);

	// no compare is pending on entry to the first level
	assign rd[0] = '0;

	for (genvar g = 0; g < NLEV; g++) begin : g_lvl
		zics_level #(
			.TABLE_DEPTH(TABLE_DEPTH)
		) u_level (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_i   (ctl[g]),
			.lo_i    (lo[g]),
			.hi_i    (hi[g]),
			.mid_i   (mid[g]),
			.addr_i  (addr[g]),
			.scaled_i(scaled[g]),
			.bound_i (bound[g]),
			.rd_i    (rd[g]),
			.ctl_o   (ctl[g+1]),
			.lo_o    (lo[g+1]),
			.hi_o    (hi[g+1]),
			.mid_o   (mid[g+1]),
			.addr_o  (addr[g+1]),
			.scaled_o(scaled[g+1]),
			.bound_o (bound[g+1]),
			.rd_o    (rd[g+1])
		);
	end

	// last compare only decides whether lo moves up
	assign lo_final = (ctl[NLEV].pend && !(scaled[NLEV] < rd[NLEV])) ? mid[NLEV] : lo[NLEV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl[NLEV].draw;
		end
	end

	always_ff @(posedge clk) begin
		rank_q <= zics_pkg::RANK_W'(lo_final);
	end

	assign done = done_q;
	assign rank = rank_q;

endmodule

### hdl/zics_checker.sv
// Port-level checks for the sampler, bound to the top level.
`timescale 1ns / 1ps

module zics_checker #(
	parameter int TABLE_DEPTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cmd,
	input logic done,
	input logic cfg_ready
);

	localparam int NLEV = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH - 1) : 1;
	localparam int LAT  = NLEV + 3;

	logic draw_acc;

	assign draw_acc = start && !busy && (cmd == zics_pkg::CMD_DRAW);

	// every accepted draw must be followed by a result
	a_draw_result: assert property (@(posedge clk) disable iff (!arst_n)
		draw_acc |-> ##LAT done)
		else $error("draw beat produced no result");

	// no result without a draw beat; loads never produce one
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(draw_acc, LAT))
		else $error("result without a matching draw beat");

	// once up, the block keeps taking commands
	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after reset");

	a_cfg_ready_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !busy)
		else $error("config ready disagrees with busy");

endmodule

bind zipf_inverse_cdf_sampler zics_checker #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_zics_checker (.*);

### dv/tb.sv
// Self-checking testbench for the Zipf inverse-CDF rank sampler.
`timescale 1ns / 1ps

module tb;
	import zics_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int ITEM_TARGET = 1850;
	// loads cause no result, so leave margin for them to clear the pipeline
	localparam int DRAIN = 20;
	localparam int DIR_ROWS = 23;
	localparam logic [RAND_W-1:0]   RV_MAX = 31'h7FFF_FFFF;
	localparam logic [WEIGHT_W-1:0] W_MAX  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic                wr_cfg;
		cfg_reg_t            reg_sel;
		logic [CFG_W-1:0]    cfg_val;
		cmd_t                op;
		logic [IDX_W-1:0]    idx;
		logic [WEIGHT_W-1:0] wt;
		logic [RAND_W-1:0]   rv;
		logic                known;
		logic [RANK_W-1:0]   rank_exp;
	} script_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                cmd;
	logic [IDX_W-1:0]    entry_index;
	logic [WEIGHT_W-1:0] entry_weight;
	logic [RAND_W-1:0]   random_value;
	logic                done;
	logic [RANK_W-1:0]   rank;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	// shadow of the block state
	bit [WEIGHT_W-1:0] cdf_shadow [TABLE_DEPTH];
	bit                cdf_loaded [TABLE_DEPTH];
	logic [SIZE_W-1:0]   ranks_in_use = TABLE_SIZE_RST;
	logic [WEIGHT_W-1:0] total_q16 = '0;

	bit [WEIGHT_W-1:0] plan_cdf [TABLE_DEPTH];
	logic [RANK_W-1:0] pending_ranks [$];
	script_row_t       script [DIR_ROWS];
	int                items_sent = 0;
	int                fail_count = 0;
	bit                burst = 1'b0;

	zipf_inverse_cdf_sampler #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.entry_index (entry_index),
		.entry_weight(entry_weight),
		.random_value(random_value),
		.done        (done),
		.rank        (rank),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// binary search over the shadow table; missing flags the first unloaded entry on the path
	function automatic logic [RANK_W-1:0] locate_rank(input logic [RAND_W-1:0] rv,
			output int missing);
		int unsigned n, lo, hi, mid;
		logic [PROD_W-1:0] sample, bound;
		missing = -1;
		n = (ranks_in_use > TABLE_DEPTH) ? TABLE_DEPTH : ranks_in_use;
		if (n < 2)
			return '0;
		lo = 0;
		hi = n - 1;
		sample = PROD_W'(rv) * PROD_W'(total_q16);
		while (lo + 1 < hi) begin
			mid = (lo + hi) / 2;
			if (!cdf_loaded[mid] && missing < 0)
				missing = mid;
			bound = PROD_W'(cdf_shadow[mid]) * PROD_W'(RV_MAX);
			if (sample < bound)
				hi = mid;
			else
				lo = mid;
		end
		return RANK_W'(lo);
	endfunction

	task automatic log_mismatch(string what, logic [RANK_W-1:0] want, logic [RANK_W-1:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch (%s) at %0t: expected %0d, got %0d", what, $time, want, got);
	endtask

	// one beat on the command port; entered and left at a rising edge
	task automatic send_item(cmd_t op, logic [IDX_W-1:0] idx, logic [WEIGHT_W-1:0] wt,
			logic [RAND_W-1:0] rv, logic known, logic [RANK_W-1:0] rank_exp);
		int gap;
		int miss;
		logic [RANK_W-1:0] r;
		gap = burst ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		entry_index <= idx;
		entry_weight <= wt;
		random_value <= rv;
		do @(posedge clk); while (busy);
		if (op == CMD_LOAD) begin
			cdf_shadow[idx] = wt;
			cdf_loaded[idx] = 1'b1;
		end else begin
			r = locate_rank(rv, miss);
			pending_ranks.push_back(known ? rank_exp : r);
		end
		items_sent++;
	endtask

	// more keeps valid high for a back-to-back write
	task automatic write_reg(cfg_reg_t sel, logic [CFG_W-1:0] val, bit more);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (sel == REG_TABLE_SIZE)
			ranks_in_use = val[SIZE_W-1:0];
		else
			total_q16 = val;
		if (!more)
			cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_ranks.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		logic [RANK_W-1:0] want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_ranks.size() == 0) begin
				log_mismatch("unexpected rank", 'x, rank);
			end else begin
				want = pending_ranks.pop_front();
				if (rank !== want)
					log_mismatch("rank", want, rank);
			end
		end
	end

	initial begin
		int n, steps, miss, shift;
		logic [SIZE_W-1:0] sz;
		logic [WEIGHT_W-1:0] tot, acc;
		logic [RAND_W-1:0] rv;
		logic [RANK_W-1:0] unused_rank;

		script = '{
			'{1'b1, REG_TABLE_SIZE,   32'd0,        CMD_DRAW, 10'd0, 32'd0, 31'd0, 1'b0, 10'd0},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_DRAW, 10'd0, 32'd0, RV_MAX, 1'b1, 10'd0},
			'{1'b1, REG_TABLE_SIZE,   32'd1,        CMD_DRAW, 10'd0, 32'd0, 31'd0, 1'b0, 10'd0},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_DRAW, 10'd0, 32'd0, 31'd0, 1'b1, 10'd0},
			'{1'b1, REG_TABLE_SIZE,   32'd2,        CMD_DRAW, 10'd0, 32'd0, 31'd0, 1'b0, 10'd0},
			// two ranks: no search, top rank never returned
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_DRAW, 10'd0, 32'd0, RV_MAX, 1'b1, 10'd0},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_LOAD, 10'd0, 32'd0, RV_MAX, 1'b0, 10'd0},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_LOAD, 10'd1, 32'h0001_0000, 31'd0,
				1'b0, 10'd0},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_LOAD, 10'd2, 32'h0002_0000, 31'd0,
				1'b0, 10'd0},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_LOAD, 10'd3, 32'h0003_0000, 31'd0,
				1'b0, 10'd0},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_LOAD, 10'd1023, W_MAX, 31'd0, 1'b0, 10'd0},
			'{1'b1, REG_TABLE_SIZE,   32'd5,        CMD_DRAW, 10'd0, 32'd0, 31'd0, 1'b0, 10'd0},
			'{1'b1, REG_TOTAL_WEIGHT, W_MAX,        CMD_DRAW, 10'd0, 32'd0, 31'd0, 1'b0, 10'd0},
			// full-scale sample never below a bound: lands on size-2
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_DRAW, 10'd0, 32'd0, RV_MAX, 1'b1, 10'd3},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_DRAW, 10'd0, 32'd0, 31'd0, 1'b1, 10'd0},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_DRAW, 10'd0, 32'd0, 31'h4000_0000,
				1'b0, 10'd0},
			'{1'b1, REG_TOTAL_WEIGHT, 32'h0002_0000, CMD_DRAW, 10'd0, 32'd0, 31'd0, 1'b0, 10'd0},
			// sample equals the bound at the midpoint: lo moves up
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_DRAW, 10'd0, 32'd0, RV_MAX, 1'b1, 10'd2},
			'{1'b1, REG_TOTAL_WEIGHT, 32'd0,        CMD_DRAW, 10'd0, 32'd0, 31'd0, 1'b0, 10'd0},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_DRAW, 10'd0, 32'd0, RV_MAX, 1'b1, 10'd0},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_LOAD, 10'h2AA, 32'hAAAA_AAAA,
				31'h2AAA_AAAA, 1'b0, 10'd0},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_LOAD, 10'h155, 32'h5555_5555,
				31'h5555_5555, 1'b0, 10'd0},
			'{1'b0, REG_TABLE_SIZE,   32'd0,        CMD_DRAW, 10'h155, 32'h5555_5555,
				31'h2AAA_AAAA, 1'b0, 10'd0}
		};

		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_LOAD;
		entry_index <= '0;
		entry_weight <= '0;
		random_value <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_TABLE_SIZE;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (script[i].wr_cfg) begin
				if (i == 0 || !script[i-1].wr_cfg)
					wait_idle();
				write_reg(script[i].reg_sel, script[i].cfg_val,
					i + 1 < DIR_ROWS && script[i+1].wr_cfg);
			end else begin
				send_item(script[i].op, script[i].idx, script[i].wt, script[i].rv,
					script[i].known, script[i].rank_exp);
			end
		end

		while (items_sent < ITEM_TARGET) begin
			// every phase starts with the sender held until all ranks are back
			wait_idle();
			case ($urandom_range(0, 9))
				0: sz = SIZE_W'($urandom_range(0, 1));
				1: sz = $urandom_range(0, 1) ? 11'd2047 : 11'd1024;
				2: sz = SIZE_W'($urandom_range(65, 2047));
				default: sz = SIZE_W'($urandom_range(2, 64));
			endcase
			n = (sz > TABLE_DEPTH) ? TABLE_DEPTH : sz;
			shift = $urandom_range(0, 4);
			acc = '0;
			// Zipf-like increments, heavy at low ranks
			for (int k = 0; k < n; k++) begin
				acc = acc + ((32'($urandom_range(1, 24'hFF_FFFF)) / (k + 1)) << shift);
				plan_cdf[k] = acc;
			end
			case ($urandom_range(0, 7))
				0: tot = '0;
				1: tot = W_MAX;
				2: tot = $urandom;
				3: tot = (n > 0) ? plan_cdf[$urandom_range(0, n - 1)] : $urandom;
				default: tot = (n > 0) ? plan_cdf[n - 1] : $urandom;
			endcase
			burst = ($urandom_range(0, 3) == 0);
			write_reg(REG_TABLE_SIZE, CFG_W'(sz), 1'b1);
			write_reg(REG_TOTAL_WEIGHT, tot, 1'b0);
			if (n <= 64) begin
				for (int k = 0; k < n; k++)
					send_item(CMD_LOAD, IDX_W'(k), plan_cdf[k], RAND_W'($urandom), 1'b0, '0);
			end
			steps = $urandom_range(10, 60);
			repeat (steps) begin
				if ($urandom_range(0, 6) == 0) begin
					send_item(CMD_LOAD, IDX_W'($urandom), $urandom, RAND_W'($urandom), 1'b0, '0);
				end else begin
					case ($urandom_range(0, 9))
						0: rv = '0;
						1: rv = RV_MAX;
						default: rv = RAND_W'($urandom);
					endcase
					// large tables fill lazily along the search path
					unused_rank = locate_rank(rv, miss);
					while (miss >= 0) begin
						send_item(CMD_LOAD, IDX_W'(miss), plan_cdf[miss], RAND_W'($urandom),
							1'b0, '0);
						unused_rank = locate_rank(rv, miss);
					end
					send_item(CMD_DRAW, IDX_W'($urandom), $urandom, rv, 1'b0, '0);
				end
			end
		end

		wait_idle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
